>>> design/rsp_pkg.sv
package rsp_pkg;

  localparam int CRD_W     = 32;
  localparam int TERM_W    = 2 * CRD_W - 16;
  localparam int DOT_W     = TERM_W + 2;
  localparam int HALF_W    = DOT_W / 2;
  localparam int PROD_W    = 2 * DOT_W + 1;
  localparam int DIFF_W    = PROD_W + 1;
  localparam int DEN_W     = DIFF_W - 1;
  localparam int NUM_W     = DEN_W + 16;
  localparam int QBITS     = 41;
  localparam int Q_W       = QBITS;
  localparam int CMP_W     = DEN_W + QBITS;
  localparam int RAD_W     = 31;
  localparam int T_W       = 31;
  localparam int S_W       = 17;
  localparam int GAP_W     = TERM_W + 2;
  localparam int SQ_W      = 2 * RAD_W;
  localparam int DIST_W    = 64;
  localparam int CFG_IDX_W = 2;

  localparam int FRONT_LAT = 4;
  localparam int MUL_LAT   = 3;
  localparam int SETUP_LAT = 2;
  localparam int DIV_LAT   = QBITS + 1;
  localparam int BACK_LAT  = 5;
  localparam int GEOM_DLY  = MUL_LAT + SETUP_LAT + DIV_LAT;
  localparam int TOTAL_LAT = FRONT_LAT + GEOM_DLY + BACK_LAT;

  localparam logic [Q_W-1:0]   QLIM  = Q_W'(1) << 40;
  localparam logic [T_W-1:0]   T_MAX = {T_W{1'b1}};
  localparam logic [S_W-1:0]   S_ONE = S_W'(65536);

  localparam logic [RAD_W-1:0] HIT_RADIUS_RST     = RAD_W'(6554);
  localparam logic [RAD_W-1:0] PARALLEL_LIMIT_RST = RAD_W'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_HIT_RADIUS     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL_LIMIT = CFG_IDX_W'(1);

  localparam int NDOT   = 5;
  localparam int DOT_DD = 0;
  localparam int DOT_AD = 1;
  localparam int DOT_AA = 2;
  localparam int DOT_DW = 3;
  localparam int DOT_AW = 4;

  localparam int NPR      = 6;
  localparam int PR_DD_AA = 0;
  localparam int PR_AD_AD = 1;
  localparam int PR_AD_AW = 2;
  localparam int PR_AA_DW = 3;
  localparam int PR_DD_AW = 4;
  localparam int PR_AD_DW = 5;

  localparam int LANE_T = 0;
  localparam int LANE_S = 1;

  typedef logic signed [CRD_W-1:0]  crd_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [DOT_W-1:0]  dot_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    crd_t [2:0] o;
    crd_t [2:0] d;
    crd_t [2:0] s;
    crd_t [2:0] a;
  } geom_t;

  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] mag;
    logic [DEN_W-1:0] den;
  } div_op_t;

  typedef struct packed {
    logic           neg;
    logic [Q_W-1:0] q;
  } quo_t;

  function automatic crd_t sat_diff(crd_t x, crd_t y);
    logic [CRD_W:0] dif;
    dif = {x[CRD_W-1], x} - {y[CRD_W-1], y};
    if (dif[CRD_W] != dif[CRD_W-1]) begin
      return dif[CRD_W] ? {1'b1, {(CRD_W-1){1'b0}}} : {1'b0, {(CRD_W-1){1'b1}}};
    end
    return dif[CRD_W-1:0];
  endfunction

  function automatic term_t fmul16(crd_t x, crd_t y);
    logic signed [2*CRD_W-1:0] p;
    p = x * y;
    return p[2*CRD_W-1:16];
  endfunction

endpackage

>>> design/rsp_front.sv
module rsp_front import rsp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_v,
  input  crd_t [2:0]       in_o,
  input  crd_t [2:0]       in_d,
  input  crd_t [2:0]       in_s,
  input  crd_t [2:0]       in_e,
  output logic             v_out,
  output dot_t [NDOT-1:0]  dots,
  output geom_t            geom
);

  logic       v0_r, v1_r, v2_r, v3_r;
  crd_t [2:0] o0_r, d0_r, s0_r, e0_r;
  geom_t      g1_r, g2_r, g3_r;
  crd_t [2:0] w1_r;
  term_t      term_r [NDOT][3];
  dot_t [NDOT-1:0] dot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= in_v;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    crd_t dk, ak, wk;
    o0_r <= in_o;
    d0_r <= in_d;
    s0_r <= in_s;
    e0_r <= in_e;
    g1_r.o <= o0_r;
    g1_r.d <= d0_r;
    g1_r.s <= s0_r;
    for (int k = 0; k < 3; k++) begin
      g1_r.a[k] <= sat_diff(e0_r[k], s0_r[k]);
      w1_r[k]   <= sat_diff(o0_r[k], s0_r[k]);
    end
    g2_r <= g1_r;
    for (int k = 0; k < 3; k++) begin
      dk = g1_r.d[k];
      ak = g1_r.a[k];
      wk = w1_r[k];
      term_r[DOT_DD][k] <= fmul16(dk, dk);
      term_r[DOT_AD][k] <= fmul16(dk, ak);
      term_r[DOT_AA][k] <= fmul16(ak, ak);
      term_r[DOT_DW][k] <= fmul16(dk, wk);
      term_r[DOT_AW][k] <= fmul16(ak, wk);
    end
    g3_r <= g2_r;
    for (int j = 0; j < NDOT; j++) begin
      dot_r[j] <= DOT_W'(term_r[j][0]) + DOT_W'(term_r[j][1]) + DOT_W'(term_r[j][2]);
    end
  end

  assign v_out = v3_r;
  assign dots  = dot_r;
  assign geom  = g3_r;

endmodule

>>> design/rsp_mul.sv
module rsp_mul import rsp_pkg::*; (
  input  logic  clk,
  input  dot_t  a,
  input  dot_t  b,
  output prod_t p
);

  localparam int MAG_W = 2 * DOT_W;

  logic             sg1_r, sg2_r;
  logic [DOT_W-1:0] ma_r, mb_r;
  logic [2*HALF_W-1:0] pp_r [4];
  prod_t            p_r;
  logic [MAG_W-1:0] sum;

  always_comb begin
    sum = (MAG_W'(pp_r[3]) << (2 * HALF_W)) + (MAG_W'(pp_r[1]) << HALF_W)
        + (MAG_W'(pp_r[2]) << HALF_W) + MAG_W'(pp_r[0]);
  end

  always_ff @(posedge clk) begin
    sg1_r <= a[DOT_W-1] ^ b[DOT_W-1];
    ma_r  <= a[DOT_W-1] ? (~a + 1'b1) : a;
    mb_r  <= b[DOT_W-1] ? (~b + 1'b1) : b;
    sg2_r <= sg1_r;
    pp_r[0] <= ma_r[HALF_W-1:0] * mb_r[HALF_W-1:0];
    pp_r[1] <= ma_r[HALF_W-1:0] * mb_r[DOT_W-1:HALF_W];
    pp_r[2] <= ma_r[DOT_W-1:HALF_W] * mb_r[HALF_W-1:0];
    pp_r[3] <= ma_r[DOT_W-1:HALF_W] * mb_r[DOT_W-1:HALF_W];
    p_r <= sg2_r ? (~{1'b0, sum} + 1'b1) : {1'b0, sum};
  end

  assign p = p_r;

endmodule

>>> design/rsp_setup.sv
module rsp_setup import rsp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               v_in,
  input  dot_t               aa,
  input  dot_t               aw,
  input  prod_t [NPR-1:0]    pr,
  input  logic [RAD_W-1:0]   plim,
  output logic               v_out,
  output div_op_t [1:0]      op
);

  logic                     va_r, vb_r;
  logic signed [DIFF_W-1:0] den_r, nt_r, ns_r;
  dot_t                     aa_r, aw_r;
  div_op_t [1:0]            op_r;
  div_op_t [1:0]            op_nxt;
  logic                     par;
  logic [DEN_W-1:0]         nt_mag, ns_mag;
  logic [DOT_W-1:0]         aw_mag;

  always_comb begin
    par = den_r[DIFF_W-1] || (den_r[DEN_W-1:0] < DEN_W'(plim)) || (den_r == '0);
    nt_mag = nt_r[DIFF_W-1] ? DEN_W'(~nt_r + 1'b1) : nt_r[DEN_W-1:0];
    ns_mag = ns_r[DIFF_W-1] ? DEN_W'(~ns_r + 1'b1) : ns_r[DEN_W-1:0];
    aw_mag = aw_r[DOT_W-1] ? (~aw_r + 1'b1) : aw_r;
    if (par) begin
      op_nxt[LANE_T].neg = 1'b0;
      op_nxt[LANE_T].mag = '0;
      op_nxt[LANE_T].den = DEN_W'(1);
      if (!aa_r[DOT_W-1] && aa_r != '0) begin
        op_nxt[LANE_S].neg = aw_r[DOT_W-1];
        op_nxt[LANE_S].mag = NUM_W'({aw_mag, 16'h0000});
        op_nxt[LANE_S].den = DEN_W'(aa_r);
      end else begin
        op_nxt[LANE_S].neg = 1'b0;
        op_nxt[LANE_S].mag = '0;
        op_nxt[LANE_S].den = DEN_W'(1);
      end
    end else begin
      op_nxt[LANE_T].neg = nt_r[DIFF_W-1];
      op_nxt[LANE_T].mag = {nt_mag, 16'h0000};
      op_nxt[LANE_T].den = den_r[DEN_W-1:0];
      op_nxt[LANE_S].neg = ns_r[DIFF_W-1];
      op_nxt[LANE_S].mag = {ns_mag, 16'h0000};
      op_nxt[LANE_S].den = den_r[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= v_in;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    den_r <= DIFF_W'(pr[PR_DD_AA]) - DIFF_W'(pr[PR_AD_AD]);
    nt_r  <= DIFF_W'(pr[PR_AD_AW]) - DIFF_W'(pr[PR_AA_DW]);
    ns_r  <= DIFF_W'(pr[PR_DD_AW]) - DIFF_W'(pr[PR_AD_DW]);
    aa_r  <= aa;
    aw_r  <= aw;
    op_r  <= op_nxt;
  end

  assign v_out = vb_r;
  assign op    = op_r;

endmodule

>>> design/rsp_div.sv
module rsp_div import rsp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          v_in,
  input  div_op_t [1:0] op,
  output logic          v_out,
  output quo_t [1:0]    quo
);

  logic             v_r   [QBITS+1];
  logic [NUM_W-1:0] rem_r [2][QBITS+1];
  logic [DEN_W-1:0] den_r [2][QBITS+1];
  logic [Q_W-1:0]   q_r   [2][QBITS+1];
  logic             neg_r [2][QBITS+1];
  logic             ovf_r [2][QBITS+1];
  logic [NUM_W-1:0] rem_nxt [2][QBITS+1];
  logic [Q_W-1:0]   q_nxt   [2][QBITS+1];

  always_comb begin
    logic [CMP_W-1:0] trial, remw;
    for (int l = 0; l < 2; l++) begin
      rem_nxt[l][0] = op[l].mag;
      q_nxt[l][0]   = '0;
      for (int k = 1; k <= QBITS; k++) begin
        trial = CMP_W'(den_r[l][k-1]) << (QBITS - k);
        remw  = CMP_W'(rem_r[l][k-1]);
        if (remw >= trial) begin
          rem_nxt[l][k] = NUM_W'(remw - trial);
          q_nxt[l][k]   = q_r[l][k-1] | (Q_W'(1) << (QBITS - k));
        end else begin
          rem_nxt[l][k] = rem_r[l][k-1];
          q_nxt[l][k]   = q_r[l][k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QBITS; k++) v_r[k] <= 1'b0;
    end else begin
      v_r[0] <= v_in;
      for (int k = 1; k <= QBITS; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      den_r[l][0] <= op[l].den;
      neg_r[l][0] <= op[l].neg;
      ovf_r[l][0] <= CMP_W'(op[l].mag) >= (CMP_W'(op[l].den) << QBITS);
      for (int k = 0; k <= QBITS; k++) begin
        rem_r[l][k] <= rem_nxt[l][k];
        q_r[l][k]   <= q_nxt[l][k];
      end
      for (int k = 1; k <= QBITS; k++) begin
        den_r[l][k] <= den_r[l][k-1];
        neg_r[l][k] <= neg_r[l][k-1];
        ovf_r[l][k] <= ovf_r[l][k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      quo[l].neg = neg_r[l][QBITS];
      quo[l].q   = (ovf_r[l][QBITS] || q_r[l][QBITS] > QLIM) ? QLIM : q_r[l][QBITS];
    end
  end

  assign v_out = v_r[QBITS];

  a_rem_t: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[QBITS] && !ovf_r[LANE_T][QBITS])
      |-> (CMP_W'(rem_r[LANE_T][QBITS]) < CMP_W'(den_r[LANE_T][QBITS])))
    else $error("t remainder not below divisor");

  a_rem_s: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[QBITS] && !ovf_r[LANE_S][QBITS])
      |-> (CMP_W'(rem_r[LANE_S][QBITS]) < CMP_W'(den_r[LANE_S][QBITS])))
    else $error("s remainder not below divisor");

endmodule

>>> design/rsp_back.sv
module rsp_back import rsp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             v_in,
  input  quo_t [1:0]       quo,
  input  geom_t            geom,
  input  logic [RAD_W-1:0] radius,
  output logic             out_strobe,
  output logic             out_hit,
  output logic [T_W-1:0]   out_ray_param
);

  logic             v0_r, v1_r, v2_r, v3_r;
  logic [T_W-1:0]   t0_r, t1_r, t2_r, t3_r;
  logic [S_W-1:0]   s0_r;
  geom_t            g0_r;
  crd_t [2:0]       o1_r, st1_r;
  term_t            dt1_r [3];
  term_t            as1_r [3];
  logic [RAD_W-1:0] ag2_r [3];
  logic             far2_r, far3_r;
  logic [SQ_W-1:0]  sq3_r [3];
  logic [SQ_W-1:0]  rr3_r;
  logic             strobe_r, hit_r;
  logic [T_W-1:0]   param_r;

  logic [T_W-1:0]   t_nxt;
  logic [S_W-1:0]   s_nxt;
  logic [RAD_W-1:0] ag_nxt [3];
  logic             far_nxt;
  logic [DIST_W-1:0] gap_sq;
  logic             hit_nxt;

  always_comb begin
    if (quo[LANE_T].neg) t_nxt = '0;
    else if (quo[LANE_T].q > Q_W'(T_MAX)) t_nxt = T_MAX;
    else t_nxt = quo[LANE_T].q[T_W-1:0];
    if (quo[LANE_S].neg) s_nxt = '0;
    else if (quo[LANE_S].q > Q_W'(S_ONE)) s_nxt = S_ONE;
    else s_nxt = quo[LANE_S].q[S_W-1:0];
  end

  always_comb begin
    logic signed [GAP_W-1:0] c, p, g;
    logic [GAP_W-1:0] ag;
    crd_t ok, sk;
    term_t dk, ak;
    far_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      ok = o1_r[k];
      sk = st1_r[k];
      dk = dt1_r[k];
      ak = as1_r[k];
      c  = GAP_W'(ok) + GAP_W'(dk);
      p  = GAP_W'(sk) + GAP_W'(ak);
      g  = c - p;
      ag = g[GAP_W-1] ? (~g + 1'b1) : g;
      ag_nxt[k] = ag[RAD_W-1:0];
      if (|ag[GAP_W-1:RAD_W]) far_nxt = 1'b1;
    end
  end

  always_comb begin
    gap_sq = DIST_W'(sq3_r[0]) + DIST_W'(sq3_r[1]) + DIST_W'(sq3_r[2]);
    hit_nxt = v3_r && !far3_r && (gap_sq < DIST_W'(rr3_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r     <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      strobe_r <= 1'b0;
      hit_r    <= 1'b0;
      param_r  <= '0;
    end else begin
      v0_r     <= v_in;
      v1_r     <= v0_r;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      strobe_r <= v3_r;
      hit_r    <= hit_nxt;
      param_r  <= hit_nxt ? t3_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    crd_t tc, sc, dk, ak;
    t0_r <= t_nxt;
    s0_r <= s_nxt;
    g0_r <= geom;
    tc = crd_t'({1'b0, t0_r});
    sc = crd_t'({{(CRD_W-S_W){1'b0}}, s0_r});
    for (int k = 0; k < 3; k++) begin
      dk = g0_r.d[k];
      ak = g0_r.a[k];
      dt1_r[k] <= fmul16(dk, tc);
      as1_r[k] <= fmul16(ak, sc);
    end
    o1_r  <= g0_r.o;
    st1_r <= g0_r.s;
    t1_r  <= t0_r;
    for (int k = 0; k < 3; k++) ag2_r[k] <= ag_nxt[k];
    far2_r <= far_nxt;
    t2_r   <= t1_r;
    for (int k = 0; k < 3; k++) sq3_r[k] <= ag2_r[k] * ag2_r[k];
    rr3_r  <= radius * radius;
    far3_r <= far2_r;
    t3_r   <= t2_r;
  end

  assign out_strobe    = strobe_r;
  assign out_hit       = hit_r;
  assign out_ray_param = param_r;

endmodule

>>> design/ray_segment_proximity_test.sv
// channel  | ports                                  | handshake
// ---------+----------------------------------------+--------------------------
// input    | in_ray_*, in_seg_* (12 x 32b signed)   | start high, busy low
// result   | out_hit, out_ray_param                 | out_strobe, one cycle
// config   | cfg_index, cfg_data                    | cfg_valid and cfg_ready
//
// one beat in per cycle, results follow in order of acceptance
// latency set mainly by the 41-step quotient pipeline plus split 50x50-bit products
// busy and cfg_ready stay constant: nothing ever stalls
// synchronous active-low reset clears valid bits and loads both config registers with defaults
module ray_segment_proximity_test import rsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CRD_W-1:0] in_ray_origin_x,
  input  logic signed [CRD_W-1:0] in_ray_origin_y,
  input  logic signed [CRD_W-1:0] in_ray_origin_z,
  input  logic signed [CRD_W-1:0] in_ray_dir_x,
  input  logic signed [CRD_W-1:0] in_ray_dir_y,
  input  logic signed [CRD_W-1:0] in_ray_dir_z,
  input  logic signed [CRD_W-1:0] in_seg_start_x,
  input  logic signed [CRD_W-1:0] in_seg_start_y,
  input  logic signed [CRD_W-1:0] in_seg_start_z,
  input  logic signed [CRD_W-1:0] in_seg_end_x,
  input  logic signed [CRD_W-1:0] in_seg_end_y,
  input  logic signed [CRD_W-1:0] in_seg_end_z,
  output logic                 out_strobe,
  output logic                 out_hit,
  output logic [T_W-1:0]       out_ray_param,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RAD_W-1:0]     cfg_data
);

  logic             accept;
  logic [RAD_W-1:0] hit_radius_r, parallel_limit_r;

  logic            fr_v;
  dot_t [NDOT-1:0] fr_dots;
  geom_t           fr_geom;

  dot_t            mul_a [NPR];
  dot_t            mul_b [NPR];
  prod_t [NPR-1:0] mul_p;

  logic            dv_r  [MUL_LAT];
  dot_t            daa_r [MUL_LAT];
  dot_t            daw_r [MUL_LAT];
  geom_t           geom_r [GEOM_DLY];

  logic            su_v;
  div_op_t [1:0]   su_op;
  logic            dq_v;
  quo_t [1:0]      dq_quo;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_radius_r     <= HIT_RADIUS_RST;
      parallel_limit_r <= PARALLEL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HIT_RADIUS:     hit_radius_r     <= cfg_data;
        CFG_PARALLEL_LIMIT: parallel_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  rsp_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_v  (accept),
    .in_o  ({in_ray_origin_z, in_ray_origin_y, in_ray_origin_x}),
    .in_d  ({in_ray_dir_z, in_ray_dir_y, in_ray_dir_x}),
    .in_s  ({in_seg_start_z, in_seg_start_y, in_seg_start_x}),
    .in_e  ({in_seg_end_z, in_seg_end_y, in_seg_end_x}),
    .v_out (fr_v),
    .dots  (fr_dots),
    .geom  (fr_geom)
  );

  always_comb begin
    mul_a[PR_DD_AA] = fr_dots[DOT_DD];  mul_b[PR_DD_AA] = fr_dots[DOT_AA];
    mul_a[PR_AD_AD] = fr_dots[DOT_AD];  mul_b[PR_AD_AD] = fr_dots[DOT_AD];
    mul_a[PR_AD_AW] = fr_dots[DOT_AD];  mul_b[PR_AD_AW] = fr_dots[DOT_AW];
    mul_a[PR_AA_DW] = fr_dots[DOT_AA];  mul_b[PR_AA_DW] = fr_dots[DOT_DW];
    mul_a[PR_DD_AW] = fr_dots[DOT_DD];  mul_b[PR_DD_AW] = fr_dots[DOT_AW];
    mul_a[PR_AD_DW] = fr_dots[DOT_AD];  mul_b[PR_AD_DW] = fr_dots[DOT_DW];
  end

  for (genvar i = 0; i < NPR; i++) begin : g_mul
    rsp_mul u_mul (
      .clk (clk),
      .a   (mul_a[i]),
      .b   (mul_b[i]),
      .p   (mul_p[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MUL_LAT; k++) dv_r[k] <= 1'b0;
    end else begin
      dv_r[0] <= fr_v;
      for (int k = 1; k < MUL_LAT; k++) dv_r[k] <= dv_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    daa_r[0]  <= fr_dots[DOT_AA];
    daw_r[0]  <= fr_dots[DOT_AW];
    geom_r[0] <= fr_geom;
    for (int k = 1; k < MUL_LAT; k++) begin
      daa_r[k] <= daa_r[k-1];
      daw_r[k] <= daw_r[k-1];
    end
    for (int k = 1; k < GEOM_DLY; k++) geom_r[k] <= geom_r[k-1];
  end

  rsp_setup u_setup (
    .clk   (clk),
    .rst_n (rst_n),
    .v_in  (dv_r[MUL_LAT-1]),
    .aa    (daa_r[MUL_LAT-1]),
    .aw    (daw_r[MUL_LAT-1]),
    .pr    (mul_p),
    .plim  (parallel_limit_r),
    .v_out (su_v),
    .op    (su_op)
  );

  rsp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .v_in  (su_v),
    .op    (su_op),
    .v_out (dq_v),
    .quo   (dq_quo)
  );

  rsp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .v_in          (dq_v),
    .quo           (dq_quo),
    .geom          (geom_r[GEOM_DLY-1]),
    .radius        (hit_radius_r),
    .out_strobe    (out_strobe),
    .out_hit       (out_hit),
    .out_ray_param (out_ray_param)
  );

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##TOTAL_LAT out_strobe)
    else $error("accepted beat did not produce a result");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, TOTAL_LAT))
    else $error("result without an accepted beat");

  a_hit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_hit |-> out_strobe)
    else $error("hit outside a result cycle");

  a_param_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ray_param != '0) |-> out_hit)
    else $error("ray parameter without hit");

endmodule

>>> dv/tb_ray_segment_proximity_test.sv
module tb_ray_segment_proximity_test;
  import rsp_pkg::*;

  localparam int WATCH_LIMIT = 4000;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    crd_t o[3];
    crd_t d[3];
    crd_t s[3];
    crd_t e[3];
  } ray_seg_t;

  typedef struct {
    logic           hit;
    logic [T_W-1:0] ray_param;
  } proximity_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  crd_t in_ray_origin_x, in_ray_origin_y, in_ray_origin_z;
  crd_t in_ray_dir_x, in_ray_dir_y, in_ray_dir_z;
  crd_t in_seg_start_x, in_seg_start_y, in_seg_start_z;
  crd_t in_seg_end_x, in_seg_end_y, in_seg_end_z;
  logic out_strobe;
  logic out_hit;
  logic [T_W-1:0] out_ray_param;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RAD_W-1:0] cfg_data;

  ray_segment_proximity_test uut (.*);

  longint radius_q;
  longint par_limit_q;
  proximity_t pending_q[$];
  int mismatches;
  int idle_pct;
  int stall_cnt;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint sat_crd(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint dot3(input longint x[3], input longint y[3]);
    longint acc;
    acc = 0;
    for (int k = 0; k < 3; k++) acc += (x[k] * y[k]) >>> 16;
    return acc;
  endfunction

  function automatic longint quotient(wide_t num, wide_t den);
    wide_t q;
    q = num / den;
    if (q > (wide_t'(1) <<< 40)) q = wide_t'(1) <<< 40;
    if (q < -(wide_t'(1) <<< 40)) q = -(wide_t'(1) <<< 40);
    return longint'(q);
  endfunction

  function automatic proximity_t closest_approach(ray_seg_t it);
    longint o[3], d[3], s0[3], a[3], w[3];
    longint dd, ad, aa, dw, aw, t, s, c, p, g, ag;
    wide_t wdd, wad, waa, wdw, waw, den, lim;
    logic [63:0] gap_sq;
    logic hit;
    proximity_t r;
    for (int k = 0; k < 3; k++) begin
      o[k] = it.o[k];
      d[k] = it.d[k];
      s0[k] = it.s[k];
      a[k] = sat_crd(longint'(it.e[k]) - s0[k]);
      w[k] = sat_crd(o[k] - s0[k]);
    end
    dd = dot3(d, d);
    ad = dot3(d, a);
    aa = dot3(a, a);
    dw = dot3(d, w);
    aw = dot3(a, w);
    wdd = dd;
    wad = ad;
    waa = aa;
    wdw = dw;
    waw = aw;
    lim = par_limit_q;
    den = wdd * waa - wad * wad;
    if (den <= 0 || den < lim) begin
      t = 0;
      s = (aa > 0) ? quotient(waw <<< 16, waa) : 0;
    end else begin
      t = quotient((wad * waw - waa * wdw) <<< 16, den);
      s = quotient((wdd * waw - wad * wdw) <<< 16, den);
    end
    if (t < 0) t = 0;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (s < 0) s = 0;
    if (s > 65536) s = 65536;
    hit = 1'b1;
    gap_sq = '0;
    for (int k = 0; k < 3; k++) begin
      c = o[k] + ((d[k] * t) >>> 16);
      p = s0[k] + ((a[k] * s) >>> 16);
      g = c - p;
      ag = (g < 0) ? -g : g;
      if (ag >= 64'sd2147483648) hit = 1'b0;
      else gap_sq += 64'(ag) * 64'(ag);
    end
    if (hit && !(gap_sq < 64'(radius_q) * 64'(radius_q))) hit = 1'b0;
    r.hit = hit;
    r.ray_param = hit ? t[T_W-1:0] : '0;
    return r;
  endfunction

  task automatic send_item(ray_seg_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_ray_origin_x <= it.o[0];
    in_ray_origin_y <= it.o[1];
    in_ray_origin_z <= it.o[2];
    in_ray_dir_x <= it.d[0];
    in_ray_dir_y <= it.d[1];
    in_ray_dir_z <= it.d[2];
    in_seg_start_x <= it.s[0];
    in_seg_start_y <= it.s[1];
    in_seg_start_z <= it.s[2];
    in_seg_end_x <= it.e[0];
    in_seg_end_y <= it.e[1];
    in_seg_end_z <= it.e[2];
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    pending_q.insert(pending_q.size(), closest_approach(it));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (TOTAL_LAT + 8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [RAD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_HIT_RADIUS) radius_q = val;
    else if (idx == CFG_PARALLEL_LIMIT) par_limit_q = val;
    @(posedge clk);
  endtask

  function automatic crd_t rnd_span(int span);
    return crd_t'($signed({1'b0, $urandom_range(2 * span)}) - span);
  endfunction

  function automatic ray_seg_t rnd_full();
    ray_seg_t it;
    for (int k = 0; k < 3; k++) begin
      it.o[k] = $urandom;
      it.d[k] = $urandom;
      it.s[k] = $urandom;
      it.e[k] = $urandom;
    end
    return it;
  endfunction

  // ray aimed at or away from a point on the segment, with jitter near the hit radius
  function automatic ray_seg_t rnd_aimed();
    ray_seg_t it;
    longint frac, pt, dv;
    int shift;
    frac = $urandom_range(65536);
    shift = $urandom_range(3);
    for (int k = 0; k < 3; k++) begin
      it.s[k] = rnd_span(1 << 21);
      it.e[k] = rnd_span(1 << 21);
      it.o[k] = rnd_span(1 << 22);
      pt = it.s[k] + (((longint'(it.e[k]) - it.s[k]) * frac) >>> 16);
      dv = pt - it.o[k] + rnd_span(6000);
      case (shift)
        0: it.d[k] = crd_t'(dv);
        1: it.d[k] = crd_t'(dv >>> 1);
        2: it.d[k] = crd_t'(dv >>> 3);
        default: it.d[k] = crd_t'(-dv);
      endcase
    end
    if ($urandom_range(7) == 0) it.d = it.e;
    if ($urandom_range(15) == 0) it.e = it.s;
    return it;
  endfunction

  ray_seg_t z_item;

  task automatic test_directed();
    ray_seg_t it;
    it = z_item;
    send_item(it);
    for (int k = 0; k < 3; k++) begin
      it.o[k] = 32'sh7fffffff;
      it.d[k] = 32'sh7fffffff;
      it.s[k] = 32'sh7fffffff;
      it.e[k] = 32'sh7fffffff;
    end
    send_item(it);
    for (int k = 0; k < 3; k++) begin
      it.o[k] = 32'sh80000000;
      it.d[k] = 32'sh80000000;
      it.s[k] = 32'sh80000000;
      it.e[k] = 32'sh80000000;
    end
    send_item(it);
    // large span and far gap
    it = z_item;
    it.s = '{32'sh80000000, 32'sh80000000, 0};
    it.e = '{32'sh7fffffff, 32'sh7fffffff, 0};
    it.o = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
    it.d = '{32'sh80000000, 32'sh7fffffff, 32'sh00010000};
    send_item(it);
    // perpendicular crossing, direct hit
    it = z_item;
    it.s = '{-32'sh00010000, 0, 0};
    it.e = '{32'sh00010000, 0, 0};
    it.o = '{0, -32'sh00050000, 0};
    it.d = '{0, 32'sh00010000, 0};
    send_item(it);
    // ray pointing away
    it.d = '{0, -32'sh00010000, 0};
    send_item(it);
    // parallel ray along the segment line
    it.o = '{-32'sh00030000, 0, 0};
    it.d = '{32'sh00020000, 0, 0};
    send_item(it);
    // parallel offset
    it.o = '{-32'sh00030000, 32'sh00000800, 0};
    send_item(it);
    // zero direction
    it.d = '{0, 0, 0};
    it.o = '{32'sh00008000, 0, 0};
    send_item(it);
    // degenerate segment
    it = z_item;
    it.s = '{32'sh00020000, 32'sh00020000, 32'sh00020000};
    it.e = it.s;
    it.d = '{32'sh00010000, 32'sh00010000, 32'sh00010000};
    send_item(it);
    // nearly parallel, small denominator
    it = z_item;
    it.e = '{32'sh00010000, 0, 0};
    it.d = '{32'sh00010000, 1, 0};
    it.o = '{0, 0, 1};
    send_item(it);
    for (int n = 0; n < 6; n++) send_item(rnd_aimed());
    for (int n = 0; n < 4; n++) send_item(rnd_full());
  endtask

  task automatic test_random(int n_items, int pct);
    idle_pct = pct;
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(99) < 15) send_item(rnd_full());
      else send_item(rnd_aimed());
    end
    idle_pct = 0;
  endtask

  always @(negedge clk) begin
    proximity_t exp_r;
    if (rst_n && out_strobe) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat hit=%0b", out_hit);
      end else begin
        exp_r = pending_q.pop_front();
        if (out_hit !== exp_r.hit || out_ray_param !== exp_r.ray_param) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit=%0b t=%0h, got hit=%0b t=%0h",
                     exp_r.hit, exp_r.ray_param, out_hit, out_ray_param);
        end
      end
    end
  end

  always @(negedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready) || !rst_n)
      stall_cnt = 0;
    else
      stall_cnt++;
    if (stall_cnt >= WATCH_LIMIT) begin
      $display("** ray_segment_proximity_test: FAILED **");
      $finish;
    end
  end

  initial begin
    z_item = '{o: '{0, 0, 0}, d: '{0, 0, 0}, s: '{0, 0, 0}, e: '{0, 0, 0}};
    mismatches = 0;
    idle_pct = 0;
    stall_cnt = 0;
    radius_q = HIT_RADIUS_RST;
    par_limit_q = PARALLEL_LIMIT_RST;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    {in_ray_origin_x, in_ray_origin_y, in_ray_origin_z} = '0;
    {in_ray_dir_x, in_ray_dir_y, in_ray_dir_z} = '0;
    {in_seg_start_x, in_seg_start_y, in_seg_start_z} = '0;
    {in_seg_end_x, in_seg_end_y, in_seg_end_z} = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(400, 0);
    drain();

    write_cfg(CFG_HIT_RADIUS, 31'h7fffffff);
    write_cfg(CFG_PARALLEL_LIMIT, 31'd0);
    test_directed();
    test_random(380, 70);
    drain();

    write_cfg(CFG_HIT_RADIUS, 31'd0);
    write_cfg(CFG_PARALLEL_LIMIT, 31'h7fffffff);
    write_cfg(CFG_IDX_W'(2), 31'h12345678);
    write_cfg(CFG_IDX_W'(3), 31'h00000001);
    test_directed();
    test_random(360, 7);
    drain();

    write_cfg(CFG_HIT_RADIUS, 31'd40000);
    write_cfg(CFG_PARALLEL_LIMIT, 31'd100000);
    test_random(400, 0);
    drain();

    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("** ray_segment_proximity_test: PASSED **");
    end else begin
      $display("** ray_segment_proximity_test: FAILED **");
    end
    $finish;
  end

endmodule
